FILE: src/haar_2d_analysis_core_assert.svh
// Assertion macros for the Haar 2D analysis core checker.
// Expects clk and rst to be visible where the macros are used.
`ifndef HAAR_2D_ANALYSIS_CORE_ASSERT_SVH
`define HAAR_2D_ANALYSIS_CORE_ASSERT_SVH

// Checked only outside reset
`define H2DA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included
`define H2DA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/h2da_pkg.sv
// Shared constants, types and helpers for the Haar 2D analysis core.
// No dependencies; used by the interfaces, line buffer, top level and checker.
package h2da_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 128;

  localparam int PIX_W  = 8;
  localparam int BAND_W = 10;
  localparam int IDX_W  = 6;
  localparam int ROW_W  = 7;
  localparam int CFG_W  = 8;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [CFG_W-1:0] HEIGHT_LIMIT = 8'd128;
  localparam logic [CFG_W-1:0] WIDTH_RESET  = 8'd128;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 8'd128;

  // Register select, taken from paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Column counter width for a given maximum row width (at least two bits)
  function automatic int col_w(input int unsigned max_width);
    int r;
    r = (max_width > 2) ? $clog2(max_width) : 2;
    return r;
  endfunction

  // Line buffer control from the counter logic
  typedef struct packed {
    logic wr_en;   // write current pixel (top row of a pair)
    logic wr_odd;  // bank select: odd column
    logic rd_en;   // read both banks (block closes on bottom row)
  } lbuf_ctrl_t;

endpackage

FILE: src/h2da_ifs.sv
// Stream interfaces of the Haar 2D analysis core: pixel input and subband output.
// Depends on h2da_pkg.
interface h2da_pixel_if;
  import h2da_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface h2da_band_if;
  import h2da_pkg::*;
  logic                     valid;
  logic                     ready;
  logic        [BAND_W-1:0] band_avg;
  logic signed [BAND_W-1:0] band_vert;
  logic signed [BAND_W-1:0] band_horz;
  logic signed [BAND_W-1:0] band_diag;
  logic        [IDX_W-1:0]  block_row;
  logic        [IDX_W-1:0]  block_col;
  logic                     last_block;

  modport source (output valid, output band_avg, output band_vert, output band_horz,
                  output band_diag, output block_row, output block_col,
                  output last_block, input ready);
  modport sink   (input valid, input band_avg, input band_vert, input band_horz,
                  input band_diag, input block_row, input block_col,
                  input last_block, output ready);
endinterface

FILE: src/haar_2d_analysis_core.sv
// Haar 2D analysis core: one-level Haar subbands of a streamed grayscale frame.
// Depends on h2da_pkg, h2da_ifs (stream interfaces) and h2da_line_buf.
//
// Usage:
//  - pixels: one 8-bit pixel per transfer in raster order; frame_start on the
//    first pixel of a frame restarts the row and column counters.
//  - bands: one transfer per 2x2 block, on the odd column of every odd row:
//    avg/vert/horz/diag subbands times two, block row/column, last_block.
//  - APB port: frame_width at 0x0, frame_height at 0x4 (bit zero ignored,
//    clamped to 2..MAX_WIDTH and 2..128). Write only while the stream is idle.
// Throughput: one pixel per cycle while pixels.ready is high. The top pixel pair
//  comes from the line store banks (read issued as the closing pixel is taken),
//  and a result passes stage 1 and then the output register before it is valid.
// Reset: counters, held pixel and both pipeline stages clear; registers go to
//  128x128. The line store is not cleared: each row pair writes its top row
//  before the bottom row reads it.
// Stall: the output register holds while bands.ready is low; one more block
//  waits in the stage behind it, and pixels.ready drops only when that stage
//  is full and cannot move.
module haar_2d_analysis_core #(
  parameter int unsigned MAX_WIDTH = h2da_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  h2da_pixel_if.sink                   pixels,
  h2da_band_if.source                  bands,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [h2da_pkg::APB_AW-1:0]  paddr,
  input  logic [h2da_pkg::APB_DW-1:0]  pwdata,
  output logic [h2da_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import h2da_pkg::*;

  localparam int CW = col_w(MAX_WIDTH);
  localparam int AW = CW - 1;
  localparam int WW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam logic [WW-1:0] WIDTH_LIM = WW'(MAX_WIDTH - (MAX_WIDTH % 2));

  // Configuration registers
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic             cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_WIDTH:  frame_width  <= pwdata[CFG_W-1:0];
        REG_HEIGHT: frame_height <= pwdata[CFG_W-1:0];
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_HEIGHT) ? APB_DW'(frame_height) : APB_DW'(frame_width);

  // Effective frame size
  logic [WW-1:0]    w_even, eff_w;
  logic [CFG_W-1:0] h_even, eff_h;

  always_comb begin
    w_even = WW'({frame_width[CFG_W-1:1], 1'b0});
    h_even = {frame_height[CFG_W-1:1], 1'b0};
    if (w_even < WW'(2))          eff_w = WW'(2);
    else if (w_even > WIDTH_LIM)  eff_w = WIDTH_LIM;
    else                          eff_w = w_even;
    if (h_even < CFG_W'(2))        eff_h = CFG_W'(2);
    else if (h_even > HEIGHT_LIMIT) eff_h = HEIGHT_LIMIT;
    else                            eff_h = h_even;
  end

  // Position counters and held bottom-left pixel
  logic [CW-1:0]    col_count, col_cur;
  logic [ROW_W-1:0] row_count, row_cur;
  logic [PIX_W-1:0] held_left;
  logic             accept, is_top, is_left, is_block, col_end, row_end;

  assign accept   = pixels.valid && pixels.ready;
  assign col_cur  = pixels.frame_start ? '0 : col_count;
  assign row_cur  = pixels.frame_start ? '0 : row_count;
  assign is_top   = !row_cur[0];
  assign is_left  = row_cur[0] && !col_cur[0];
  assign is_block = row_cur[0] && col_cur[0];
  assign col_end  = (WW'(col_cur) + WW'(1)) >= eff_w;
  assign row_end  = (CFG_W'(row_cur) + CFG_W'(1)) >= eff_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      held_left <= '0;
    end else if (accept) begin
      if (is_left) begin
        held_left <= pixels.pixel;
      end
      if (col_end) begin
        col_count <= '0;
        row_count <= row_end ? '0 : row_cur + ROW_W'(1);
      end else begin
        col_count <= col_cur + CW'(1);
        row_count <= row_cur;
      end
    end
  end

  // Line store: write on top rows, read the pair when a block closes
  lbuf_ctrl_t       lb_ctrl;
  logic [AW-1:0]    lb_addr;
  logic [PIX_W-1:0] top_left, top_right;

  assign lb_ctrl.wr_en  = accept && is_top;
  assign lb_ctrl.wr_odd = col_cur[0];
  assign lb_ctrl.rd_en  = accept && is_block;
  assign lb_addr        = col_cur[CW-1:1];

  h2da_line_buf #(.MAX_WIDTH(MAX_WIDTH)) u_lbuf (
    .clk     (clk),
    .ctrl    (lb_ctrl),
    .addr    (lb_addr),
    .wdata   (pixels.pixel),
    .rd_even (top_left),
    .rd_odd  (top_right)
  );

  // Stage 1: bottom pixels and block position wait for the line store read
  logic             s1_valid, s1_move, out_free;
  logic [PIX_W-1:0] s1_c, s1_d;
  logic [IDX_W-1:0] s1_row, s1_col;
  logic             s1_last;
  logic [CW-1:0]    col_half;

  assign col_half     = col_cur >> 1;
  assign out_free     = !bands.valid || bands.ready;
  assign s1_move      = s1_valid && out_free;
  assign pixels.ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept && is_block) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_block) begin
      s1_c    <= held_left;
      s1_d    <= pixels.pixel;
      s1_row  <= IDX_W'(row_cur >> 1);
      s1_col  <= IDX_W'(col_half);
      s1_last <= row_end && col_end;
    end
  end

  // Stage 2: subband sums into the output register
  logic [BAND_W-1:0] a_x, b_x, c_x, d_x;

  assign a_x = BAND_W'(top_left);
  assign b_x = BAND_W'(top_right);
  assign c_x = BAND_W'(s1_c);
  assign d_x = BAND_W'(s1_d);

  always_ff @(posedge clk) begin
    if (rst) begin
      bands.valid <= 1'b0;
    end else if (s1_move) begin
      bands.valid <= 1'b1;
    end else if (bands.ready) begin
      bands.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      bands.band_avg   <= a_x + b_x + c_x + d_x;
      bands.band_vert  <= $signed(a_x + b_x - c_x - d_x);
      bands.band_horz  <= $signed(a_x - b_x + c_x - d_x);
      bands.band_diag  <= $signed(a_x - b_x - c_x + d_x);
      bands.block_row  <= s1_row;
      bands.block_col  <= s1_col;
      bands.last_block <= s1_last;
    end
  end

endmodule

FILE: src/h2da_line_buf.sv
// One-row line store, split in an even-column and an odd-column bank.
// Synchronous memories with registered reads. Depends on h2da_pkg.
module h2da_line_buf #(
  parameter int unsigned MAX_WIDTH = h2da_pkg::MAX_WIDTH_DEF
) (
  input  logic                                         clk,
  input  h2da_pkg::lbuf_ctrl_t                         ctrl,
  input  logic [h2da_pkg::col_w(MAX_WIDTH)-2:0]        addr,
  input  logic [h2da_pkg::PIX_W-1:0]                   wdata,
  output logic [h2da_pkg::PIX_W-1:0]                   rd_even,
  output logic [h2da_pkg::PIX_W-1:0]                   rd_odd
);
  import h2da_pkg::*;

  localparam int AW         = col_w(MAX_WIDTH) - 1;
  localparam int BANK_DEPTH = 1 << AW;

  logic [PIX_W-1:0] even_mem [BANK_DEPTH];
  logic [PIX_W-1:0] odd_mem  [BANK_DEPTH];

  // Even bank: column 2k
  always_ff @(posedge clk) begin
    if (ctrl.wr_en && !ctrl.wr_odd) begin
      even_mem[addr] <= wdata;
    end
    if (ctrl.rd_en) begin
      rd_even <= even_mem[addr];
    end
  end

  // Odd bank: column 2k+1
  always_ff @(posedge clk) begin
    if (ctrl.wr_en && ctrl.wr_odd) begin
      odd_mem[addr] <= wdata;
    end
    if (ctrl.rd_en) begin
      rd_odd <= odd_mem[addr];
    end
  end

endmodule

FILE: src/h2da_checker.sv
// Port-level checks for the Haar 2D analysis core, bound to the top level.
// Depends on h2da_pkg and haar_2d_analysis_core_assert.svh.
`include "haar_2d_analysis_core_assert.svh"

module h2da_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic        [h2da_pkg::BAND_W-1:0] band_avg,
  input logic signed [h2da_pkg::BAND_W-1:0] band_vert,
  input logic signed [h2da_pkg::BAND_W-1:0] band_horz,
  input logic signed [h2da_pkg::BAND_W-1:0] band_diag,
  input logic        [h2da_pkg::IDX_W-1:0]  block_row,
  input logic        [h2da_pkg::IDX_W-1:0]  block_col,
  input logic                               last_block
);
  import h2da_pkg::*;

  // The four bands add up to four times the top-left pixel
  logic [BAND_W-1:0] band_sum;
  assign band_sum = band_avg + $unsigned(band_vert) + $unsigned(band_horz)
                  + $unsigned(band_diag);

  // Handshake shorthands and the whole result word
  logic                        in_xfer;
  logic                        stalled;
  logic [4*BAND_W+2*IDX_W:0]   out_word;

  assign in_xfer  = in_valid && in_ready;
  assign stalled  = out_valid && !out_ready;
  assign out_word = {band_avg, band_vert, band_horz, band_diag,
                     block_row, block_col, last_block};

  // Output stage empties on reset
  `H2DA_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "output valid after reset")

  // Stalled result holds
  `H2DA_ASSERT(a_stall_hold, stalled |=> out_valid && $stable(out_word), "stalled result changed")

  // A fresh result must have a pixel transfer before it
  `H2DA_ASSERT(a_fresh_latency, $rose(out_valid) |-> $past(in_xfer, 2), "no closing pixel")

  // Subband consistency
  `H2DA_ASSERT(a_band_sum, out_valid |-> band_sum[1:0] == 2'b00, "subbands inconsistent")

endmodule

bind haar_2d_analysis_core h2da_checker u_h2da_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (pixels.valid),
  .in_ready   (pixels.ready),
  .out_valid  (bands.valid),
  .out_ready  (bands.ready),
  .band_avg   (bands.band_avg),
  .band_vert  (bands.band_vert),
  .band_horz  (bands.band_horz),
  .band_diag  (bands.band_diag),
  .block_row  (bands.block_row),
  .block_col  (bands.block_col),
  .last_block (bands.last_block)
);
